[rtl/tree_lca_distance_query_unit_assert.svh]
// Assertion macros for the tree LCA distance query unit.
// Uses the i_clk / i_rst_n names of the including module; no other dependencies.
`ifndef TREE_LCA_DISTANCE_QUERY_UNIT_ASSERT_SVH
`define TREE_LCA_DISTANCE_QUERY_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define TLCAQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tlcaq: same-cycle check failed");

// Next-cycle implication, disabled in reset
`define TLCAQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tlcaq: next-cycle check failed");

`endif

[rtl/tlcaq_pkg.sv]
// Shared constants, types and address helper for the tree LCA distance query unit.
// No dependencies.
package tlcaq_pkg;

    localparam int NODE_W     = 10;
    localparam int MAX_NODES  = 2 ** NODE_W;
    localparam int LEVELS     = 10;
    localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int DEPTH_W    = 10;
    localparam int DIST_W     = 26;
    localparam int WEIGHT_W   = 16;
    localparam int NODE_REC_W = DEPTH_W + DIST_W;
    localparam int ANC_DEPTH  = MAX_NODES * LEVELS;
    localparam int ANC_AW     = $clog2(ANC_DEPTH);

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
    localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
    localparam logic [LVL_W-1:0]   LAST_LVL  = LVL_W'(LEVELS - 1);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_QUERY  = 1'b1
    } t_cmd;

    // Flat ancestor table address: node * LEVELS + level
    function automatic logic [ANC_AW-1:0] anc_addr(input logic [NODE_W-1:0] node,
                                                   input logic [LVL_W-1:0]  lvl);
        anc_addr = ANC_AW'(node) * ANC_AW'(LEVELS) + ANC_AW'(lvl);
    endfunction

endpackage

[rtl/tlcaq_ram.sv]
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module tlcaq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re0,
    input  logic [AW-1:0]    i_raddr0,
    output logic [WIDTH-1:0] o_rdata0,
    input  logic             i_re1,
    input  logic [AW-1:0]    i_raddr1,
    output logic [WIDTH-1:0] o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re0) begin
            o_rdata0 <= r_mem[i_raddr0];
        end
        if (i_re1) begin
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

[rtl/tree_lca_distance_query_unit.sv]
// Insert: busy after the accept (root or not) while ancestor levels are written; no result.
// Query: busy until the result; the descent is skipped when one node is the
// other's ancestor; o_valid strobes one cycle, in the first cycle busy is low again.
// Throughput is one level per cycle, set by the registered read of the ancestor RAM.
// Synchronous active-low reset clears the sequencer and the strobe; RAM contents
// are undefined until written, no clearing pass. The receiver cannot stall.
module tree_lca_distance_query_unit
    import tlcaq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cmd,
    input  logic [NODE_W-1:0]   i_node_a,
    input  logic [NODE_W-1:0]   i_node_b,
    input  logic [WEIGHT_W-1:0] i_edge_weight,
    output logic                o_valid,
    output logic [NODE_W-1:0]   o_ancestor,
    output logic [DIST_W-1:0]   o_distance
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROOT,
        S_NODE,
        S_CHAIN,
        S_Q_SWAP,
        S_Q_LIFT,
        S_Q_LEND,
        S_Q_DESC,
        S_Q_PAR,
        S_Q_DIST
    } t_state;

    t_state               r_state, n_state;
    logic [LVL_W-1:0]     r_k, n_k;
    logic [NODE_W-1:0]    r_a, n_a;
    logic [NODE_W-1:0]    r_b, n_b;
    logic [NODE_W-1:0]    r_cur, n_cur;
    logic [NODE_W-1:0]    r_p, n_p;
    logic [WEIGHT_W-1:0]  r_w, n_w;
    logic                 r_fwd, n_fwd;
    logic                 r_pend, n_pend;
    logic [DEPTH_W-1:0]   r_diff, n_diff;
    logic [DIST_W:0]      r_sum, n_sum;
    logic                 r_valid, n_valid;
    logic [NODE_W-1:0]    r_anc_out, n_anc_out;
    logic [DIST_W-1:0]    r_dist_out, n_dist_out;

    // memory ports
    logic                  anc_we, anc_re0, anc_re1;
    logic [ANC_AW-1:0]     anc_waddr, anc_raddr0, anc_raddr1;
    logic [NODE_W-1:0]     anc_wdata, anc_rd0, anc_rd1;
    logic                  node_we, node_re0, node_re1;
    logic [NODE_W-1:0]     node_waddr, node_raddr0, node_raddr1;
    logic [NODE_REC_W-1:0] node_wdata, node_rd0, node_rd1;

    // datapath helpers
    logic [DEPTH_W-1:0]    par_depth, dep_a, dep_b, new_depth;
    logic [DIST_W-1:0]     par_dist, dist_a, dist_b, dist_p;
    logic [DIST_W:0]       dist_sum;
    logic [DIST_W-1:0]     new_dist;
    logic [DIST_W+1:0]     path_diff;
    logic [NODE_W-1:0]     chain_data, b_now, a_next, b_next;
    logic                  differ;

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_ancestor = r_anc_out;
    assign o_distance = r_dist_out;

    // node record fields
    assign par_depth = node_rd0[NODE_REC_W-1 -: DEPTH_W];
    assign par_dist  = node_rd0[DIST_W-1:0];
    assign dep_a     = node_rd0[NODE_REC_W-1 -: DEPTH_W];
    assign dist_a    = node_rd0[DIST_W-1:0];
    assign dep_b     = node_rd1[NODE_REC_W-1 -: DEPTH_W];
    assign dist_b    = node_rd1[DIST_W-1:0];
    assign dist_p    = node_rd0[DIST_W-1:0];

    // child depth and root distance, both saturating
    assign new_depth = (par_depth == DEPTH_MAX) ? DEPTH_MAX : par_depth + 1'b1;
    assign dist_sum  = {1'b0, par_dist} + (DIST_W+1)'(r_w);
    assign new_dist  = dist_sum[DIST_W] ? DIST_MAX : dist_sum[DIST_W-1:0];

    // path distance: dist(a) + dist(b) - 2 * dist(lca), clamped to [0, max]
    assign path_diff = {1'b0, r_sum} - {1'b0, dist_p, 1'b0};

    // ancestor chain value, forwarded when the last read hit the entry being written
    assign chain_data = r_fwd ? r_cur : anc_rd0;

    // lifted node: last read result if a jump was taken
    assign b_now = r_pend ? anc_rd0 : r_b;

    // descent step: move both nodes up where their 2^k ancestors differ
    assign differ = (anc_rd0 != anc_rd1);
    assign a_next = differ ? anc_rd0 : r_a;
    assign b_next = differ ? anc_rd1 : r_b;

    // sequencer and memory control
    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_a        = r_a;
        n_b        = r_b;
        n_cur      = r_cur;
        n_p        = r_p;
        n_w        = r_w;
        n_fwd      = r_fwd;
        n_pend     = r_pend;
        n_diff     = r_diff;
        n_sum      = r_sum;
        n_valid    = 1'b0;
        n_anc_out  = r_anc_out;
        n_dist_out = r_dist_out;

        anc_we      = 1'b0;
        anc_waddr   = anc_addr(r_a, r_k);
        anc_wdata   = r_a;
        anc_re0     = 1'b0;
        anc_raddr0  = anc_addr(r_a, r_k);
        anc_re1     = 1'b0;
        anc_raddr1  = anc_addr(r_b, r_k);
        node_we     = 1'b0;
        node_waddr  = r_a;
        node_wdata  = {new_depth, new_dist};
        node_re0    = 1'b0;
        node_raddr0 = r_a;
        node_re1    = 1'b0;
        node_raddr1 = r_b;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_a = i_node_a;
                    n_b = i_node_b;
                    n_w = i_edge_weight;
                    n_k = LVL_W'(1);
                    if (t_cmd'(i_cmd) == CMD_QUERY) begin
                        node_re0    = 1'b1;
                        node_raddr0 = i_node_a;
                        node_re1    = 1'b1;
                        node_raddr1 = i_node_b;
                        n_state     = S_Q_SWAP;
                    end else if (i_node_a == i_node_b) begin
                        // root: depth 0, distance 0, own ancestor at level 0
                        node_we    = 1'b1;
                        node_waddr = i_node_a;
                        node_wdata = '0;
                        anc_we     = 1'b1;
                        anc_waddr  = anc_addr(i_node_a, '0);
                        anc_wdata  = i_node_a;
                        n_state    = (LEVELS > 1) ? S_ROOT : S_IDLE;
                    end else begin
                        // child: parent record read, level 0 written, chain started
                        node_re0    = 1'b1;
                        node_raddr0 = i_node_b;
                        anc_we      = 1'b1;
                        anc_waddr   = anc_addr(i_node_a, '0);
                        anc_wdata   = i_node_b;
                        anc_re0     = 1'b1;
                        anc_raddr0  = anc_addr(i_node_b, '0);
                        n_cur       = i_node_b;
                        n_fwd       = 1'b0;
                        n_state     = (LEVELS > 1) ? S_CHAIN : S_NODE;
                    end
                end
            end

            S_ROOT: begin
                anc_we    = 1'b1;
                anc_wdata = r_a;
                if (r_k == LAST_LVL) begin
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end

            S_NODE: begin
                node_we = 1'b1;
                n_state = S_IDLE;
            end

            S_CHAIN: begin
                // ancestor[u][k] = ancestor[ancestor[u][k-1]][k-1]
                anc_we    = 1'b1;
                anc_wdata = chain_data;
                n_cur     = chain_data;
                node_we   = (r_k == LVL_W'(1));
                if (r_k == LAST_LVL) begin
                    n_state = S_IDLE;
                end else begin
                    anc_re0    = 1'b1;
                    anc_raddr0 = anc_addr(chain_data, r_k);
                    n_fwd      = (chain_data == r_a);
                    n_k        = r_k + 1'b1;
                end
            end

            S_Q_SWAP: begin
                // deeper node goes to b
                n_sum  = {1'b0, dist_a} + {1'b0, dist_b};
                n_k    = '0;
                n_pend = 1'b0;
                if (dep_a > dep_b) begin
                    n_a    = r_b;
                    n_b    = r_a;
                    n_diff = dep_a - dep_b;
                end else begin
                    n_diff = dep_b - dep_a;
                end
                n_state = S_Q_LIFT;
            end

            S_Q_LIFT: begin
                n_b    = b_now;
                n_pend = r_diff[0];
                n_diff = r_diff >> 1;
                if (r_diff[0]) begin
                    anc_re0    = 1'b1;
                    anc_raddr0 = anc_addr(b_now, r_k);
                end
                if (r_k == LAST_LVL) begin
                    n_state = S_Q_LEND;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end

            S_Q_LEND: begin
                n_b = b_now;
                if (r_a == b_now) begin
                    n_p         = r_a;
                    node_re0    = 1'b1;
                    node_raddr0 = r_a;
                    n_state     = S_Q_DIST;
                end else begin
                    anc_re0    = 1'b1;
                    anc_raddr0 = anc_addr(r_a, LAST_LVL);
                    anc_re1    = 1'b1;
                    anc_raddr1 = anc_addr(b_now, LAST_LVL);
                    n_k        = LAST_LVL;
                    n_state    = S_Q_DESC;
                end
            end

            S_Q_DESC: begin
                n_a = a_next;
                n_b = b_next;
                anc_re0 = 1'b1;
                if (r_k == '0) begin
                    anc_raddr0 = anc_addr(a_next, '0);
                    n_state    = S_Q_PAR;
                end else begin
                    anc_raddr0 = anc_addr(a_next, r_k - 1'b1);
                    anc_re1    = 1'b1;
                    anc_raddr1 = anc_addr(b_next, r_k - 1'b1);
                    n_k        = r_k - 1'b1;
                end
            end

            S_Q_PAR: begin
                n_p         = anc_rd0;
                node_re0    = 1'b1;
                node_raddr0 = anc_rd0;
                n_state     = S_Q_DIST;
            end

            S_Q_DIST: begin
                n_valid   = 1'b1;
                n_anc_out = r_p;
                if (path_diff[DIST_W+1]) begin
                    n_dist_out = '0;
                end else if (path_diff[DIST_W]) begin
                    n_dist_out = DIST_MAX;
                end else begin
                    n_dist_out = path_diff[DIST_W-1:0];
                end
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_a        <= n_a;
        r_b        <= n_b;
        r_cur      <= n_cur;
        r_p        <= n_p;
        r_w        <= n_w;
        r_fwd      <= n_fwd;
        r_pend     <= n_pend;
        r_diff     <= n_diff;
        r_sum      <= n_sum;
        r_anc_out  <= n_anc_out;
        r_dist_out <= n_dist_out;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // 2^k ancestor table, node * LEVELS + k
    tlcaq_ram #(
        .WIDTH (NODE_W),
        .DEPTH (ANC_DEPTH)
    ) u_anc_ram (
        .i_clk    (i_clk),
        .i_we     (anc_we),
        .i_waddr  (anc_waddr),
        .i_wdata  (anc_wdata),
        .i_re0    (anc_re0),
        .i_raddr0 (anc_raddr0),
        .o_rdata0 (anc_rd0),
        .i_re1    (anc_re1),
        .i_raddr1 (anc_raddr1),
        .o_rdata1 (anc_rd1)
    );

    // per-node {depth, root distance}
    tlcaq_ram #(
        .WIDTH (NODE_REC_W),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .i_clk    (i_clk),
        .i_we     (node_we),
        .i_waddr  (node_waddr),
        .i_wdata  (node_wdata),
        .i_re0    (node_re0),
        .i_raddr0 (node_raddr0),
        .o_rdata0 (node_rd0),
        .i_re1    (node_re1),
        .i_raddr1 (node_raddr1),
        .o_rdata1 (node_rd1)
    );

`include "tree_lca_distance_query_unit_assert.svh"

    // a result strobe lasts one cycle and arrives with the block free again
    `TLCAQ_ASSERT_NEXT(a_valid_single, o_valid, !o_valid)
    `TLCAQ_ASSERT_NOW(a_valid_idle, o_valid, !busy)
    // the final distance step always produces a transaction
    `TLCAQ_ASSERT_NEXT(a_dist_strobe, r_state == S_Q_DIST, o_valid)
    // query walks never write the tables
    `TLCAQ_ASSERT_NOW(a_query_no_write, (r_state == S_Q_LIFT) || (r_state == S_Q_DESC), !anc_we && !node_we)

endmodule
